// ===== src/uekf_pkg.sv =====
`default_nettype none
package uekf_pkg;

    localparam logic [33:0] TWO_PI_Q   = 34'd411775;
    localparam logic [33:0] PI_Q       = 34'd205887;
    localparam logic [33:0] WRAP_BIAS  = 34'd3373260800;
    localparam logic signed [19:0] PI_S      = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_S = 20'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [4:0] CORDIC_LAST = 5'd23;
    localparam logic [4:0] WRAP_FIRST  = 5'd13;

    typedef enum logic [4:0] {
        S_IDLE, S_MWT, S_MIDLD, S_MOD1, S_CINIT, S_CORD, S_MTC, S_MTS, S_MVX,
        S_MVY, S_MXT, S_MYT, S_MGT, S_THLD, S_MOD2, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_W_T, MUL_G_T, MUL_T_C, MUL_T_S, MUL_V_X, MUL_V_Y, MUL_X_T, MUL_NY_T
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mid_load;
        logic     th_load;
        logic     mod_step;
        logic     cord_init;
        logic     cord_step;
        logic     xdir_ld;
        logic     ydir_ld;
        logic     xinc_ld;
        logic     yinc_ld;
        logic     jwx_ld;
        logic     jwy_ld;
        logic     out_load;
        logic [4:0] cnt;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:    return 34'h03243F6A8;
            5'd1:    return 34'h01DAC6705;
            5'd2:    return 34'h00FADBAFC;
            5'd3:    return 34'h007F56EA6;
            5'd4:    return 34'h003FEAB76;
            5'd5:    return 34'h001FFD55B;
            5'd6:    return 34'h000FFFAAA;
            5'd7:    return 34'h0007FFF55;
            5'd8:    return 34'h0003FFFEA;
            5'd9:    return 34'h0001FFFFD;
            5'd10:   return 34'h0000FFFFF;
            5'd11:   return 34'h00007FFFF;
            5'd12:   return 34'h00003FFFF;
            5'd13:   return 34'h00001FFFF;
            5'd14:   return 34'h00000FFFF;
            5'd15:   return 34'h000007FFF;
            5'd16:   return 34'h000003FFF;
            5'd17:   return 34'h000001FFF;
            5'd18:   return 34'h000000FFF;
            5'd19:   return 34'h0000007FF;
            5'd20:   return 34'h0000003FF;
            5'd21:   return 34'h0000001FF;
            5'd22:   return 34'h0000000FF;
            5'd23:   return 34'h00000007F;
            default: return 34'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== src/uekf_in_if.sv =====
`default_nettype none
interface uekf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [18:0] pose_theta;
    logic signed [31:0] pose_v;
    logic signed [31:0] pose_w;
    logic signed [31:0] gyro_z;
    logic signed [31:0] wheel_left;
    logic signed [31:0] wheel_right;
    logic        [15:0] time_step;

    modport source (output valid, pose_x, pose_y, pose_theta, pose_v, pose_w, gyro_z,
                    wheel_left, wheel_right, time_step, input ready);
    modport sink (input valid, pose_x, pose_y, pose_theta, pose_v, pose_w, gyro_z,
                  wheel_left, wheel_right, time_step, output ready);
endinterface
`default_nettype wire

// ===== src/uekf_out_if.sv =====
`default_nettype none
interface uekf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [18:0] pred_theta;
    logic signed [31:0] pred_v;
    logic signed [31:0] pred_w;
    logic signed [31:0] jac_theta_x;
    logic signed [31:0] jac_theta_y;
    logic signed [31:0] jac_v_x;
    logic signed [31:0] jac_v_y;
    logic signed [31:0] jac_w_x;
    logic signed [31:0] jac_w_y;

    modport source (output valid, pred_x, pred_y, pred_theta, pred_v, pred_w,
                    jac_theta_x, jac_theta_y, jac_v_x, jac_v_y, jac_w_x, jac_w_y,
                    input ready);
    modport sink (input valid, pred_x, pred_y, pred_theta, pred_v, pred_w,
                  jac_theta_x, jac_theta_y, jac_v_x, jac_v_y, jac_w_x, jac_w_y,
                  output ready);
endinterface
`default_nettype wire

// ===== src/unicycle_ekf_predict.sv =====
`default_nettype none
// An item is not accepted until the previous one has reached the output register;
// the 24-step CORDIC, two 14-step angle wraps and eight passes through the single
// shared multiplier lie between an accepted item and its result.
// A new item is accepted while the previous result still waits to be taken.
// Reset is asynchronous and active low; it clears the controller and the stored
// last gyro rate and last wheel speed to zero.
module unicycle_ekf_predict (
    input  wire logic clk,
    input  wire logic rst_n,
    uekf_in_if.sink   in_ch,
    uekf_out_if.source out_ch
);
    import uekf_pkg::*;

    cmd_t cmd;

    uekf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    uekf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .pose_x      (in_ch.pose_x),
        .pose_y      (in_ch.pose_y),
        .pose_theta  (in_ch.pose_theta),
        .pose_v      (in_ch.pose_v),
        .pose_w      (in_ch.pose_w),
        .gyro_z      (in_ch.gyro_z),
        .wheel_left  (in_ch.wheel_left),
        .wheel_right (in_ch.wheel_right),
        .time_step   (in_ch.time_step),
        .pred_x      (out_ch.pred_x),
        .pred_y      (out_ch.pred_y),
        .pred_theta  (out_ch.pred_theta),
        .pred_v      (out_ch.pred_v),
        .pred_w      (out_ch.pred_w),
        .jac_theta_x (out_ch.jac_theta_x),
        .jac_theta_y (out_ch.jac_theta_y),
        .jac_v_x     (out_ch.jac_v_x),
        .jac_v_y     (out_ch.jac_v_y),
        .jac_w_x     (out_ch.jac_w_x),
        .jac_w_y     (out_ch.jac_w_y)
    );

endmodule
`default_nettype wire

// ===== src/uekf_ctrl.sv =====
`default_nettype none
module uekf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          out_ready,
    output uekf_pkg::cmd_t     cmd,
    output logic               in_ready,
    output logic               out_valid
);
    import uekf_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MWT;
            S_MWT:   state_next = S_MIDLD;
            S_MIDLD:
            begin
                state_next = S_MOD1;
                cnt_next   = WRAP_FIRST;
            end
            S_MOD1:
            begin
                if (cnt_reg == '0)
                    state_next = S_CINIT;
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            S_CINIT:
            begin
                state_next = S_CORD;
                cnt_next   = '0;
            end
            S_CORD:
            begin
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_MTC;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_MTC:   state_next = S_MTS;
            S_MTS:   state_next = S_MVX;
            S_MVX:   state_next = S_MVY;
            S_MVY:   state_next = S_MXT;
            S_MXT:   state_next = S_MYT;
            S_MYT:   state_next = S_MGT;
            S_MGT:   state_next = S_THLD;
            S_THLD:
            begin
                state_next = S_MOD2;
                cnt_next   = WRAP_FIRST;
            end
            S_MOD2:
            begin
                if (cnt_reg == '0)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_W_T;
        cmd.cnt     = cnt_reg;
        ov_next     = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE:  cmd.load = in_valid;
            S_MWT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_W_T;
            end
            S_MIDLD: cmd.mid_load = 1'b1;
            S_MOD1:  cmd.mod_step = 1'b1;
            S_CINIT: cmd.cord_init = 1'b1;
            S_CORD:  cmd.cord_step = 1'b1;
            S_MTC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T_C;
            end
            S_MTS:
            begin
                cmd.xdir_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T_S;
            end
            S_MVX:
            begin
                cmd.ydir_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V_X;
            end
            S_MVY:
            begin
                cmd.xinc_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V_Y;
            end
            S_MXT:
            begin
                cmd.yinc_ld = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X_T;
            end
            S_MYT:
            begin
                cmd.jwy_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NY_T;
            end
            S_MGT:
            begin
                cmd.jwx_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_G_T;
            end
            S_THLD:  cmd.th_load = 1'b1;
            S_MOD2:  cmd.mod_step = 1'b1;
            S_DONE:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    ov_next = 1'b1;
            end
            default: cmd.load = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/uekf_dp.sv =====
`default_nettype none
module uekf_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire uekf_pkg::cmd_t     cmd,
    input  wire logic signed [31:0] pose_x,
    input  wire logic signed [31:0] pose_y,
    input  wire logic signed [18:0] pose_theta,
    input  wire logic signed [31:0] pose_v,
    input  wire logic signed [31:0] pose_w,
    input  wire logic signed [31:0] gyro_z,
    input  wire logic signed [31:0] wheel_left,
    input  wire logic signed [31:0] wheel_right,
    input  wire logic        [15:0] time_step,
    output logic signed [31:0]      pred_x,
    output logic signed [31:0]      pred_y,
    output logic signed [18:0]      pred_theta,
    output logic signed [31:0]      pred_v,
    output logic signed [31:0]      pred_w,
    output logic signed [31:0]      jac_theta_x,
    output logic signed [31:0]      jac_theta_y,
    output logic signed [31:0]      jac_v_x,
    output logic signed [31:0]      jac_v_y,
    output logic signed [31:0]      jac_w_x,
    output logic signed [31:0]      jac_w_y
);
    import uekf_pkg::*;

    logic signed [31:0] px_reg, py_reg, v_reg, w_reg, g_reg;
    logic signed [18:0] th_reg;
    logic        [15:0] t_reg;
    logic signed [31:0] pv_reg, pw_reg;
    logic signed [31:0] prev_gyro_reg, prev_wheel_reg;
    logic signed [65:0] prod_reg;
    logic        [33:0] rem_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [17:0] xdir_reg, ydir_reg;
    logic signed [31:0] xinc_reg, yinc_reg, jwx_reg, jwy_reg;

    logic signed [32:0] wsum;
    logic signed [31:0] vel;
    logic signed [33:0] pv_sum, pw_sum;
    logic signed [32:0] ma, mb, t_s, cos_s, sin_s, nyinc;
    logic signed [33:0] cos_v, sin_v;
    logic        [33:0] wrap_in, sub_val;
    logic signed [19:0] ang, ang_f;
    logic               ang_neg;
    logic signed [33:0] xs, ys;
    logic        [33:0] at;
    logic signed [19:0] theta_w;
    logic signed [32:0] sx_sum, sy_sum;

    assign wsum   = {wheel_left[31], wheel_left} + {wheel_right[31], wheel_right};
    assign vel    = wsum[32:1];
    assign pv_sum = {{2{pose_v[31]}}, pose_v} + {{2{vel[31]}}, vel}
                    - {{2{prev_wheel_reg[31]}}, prev_wheel_reg};
    assign pw_sum = {{2{pose_w[31]}}, pose_w} + {{2{gyro_z[31]}}, gyro_z}
                    - {{2{prev_gyro_reg[31]}}, prev_gyro_reg};

    assign t_s   = {17'd0, t_reg};
    assign cos_v = neg_reg ? -cx_reg : cx_reg;
    assign sin_v = neg_reg ? -cy_reg : cy_reg;
    assign cos_s = cos_v[32:0];
    assign sin_s = sin_v[32:0];
    assign nyinc = -{yinc_reg[31], yinc_reg};

    always_comb
    begin
        ma = {w_reg[31], w_reg};
        mb = t_s;
        case (cmd.mul_sel)
            MUL_W_T:  ma = {w_reg[31], w_reg};
            MUL_G_T:  ma = {g_reg[31], g_reg};
            MUL_T_C:  ma = cos_s;
            MUL_T_S:  ma = sin_s;
            MUL_V_X:
            begin
                ma = {v_reg[31], v_reg};
                mb = {{15{xdir_reg[17]}}, xdir_reg};
            end
            MUL_V_Y:
            begin
                ma = {v_reg[31], v_reg};
                mb = {{15{ydir_reg[17]}}, ydir_reg};
            end
            MUL_X_T:  ma = {xinc_reg[31], xinc_reg};
            MUL_NY_T: ma = nyinc;
            default:  ma = {w_reg[31], w_reg};
        endcase
    end

    always_comb
    begin
        if (cmd.mid_load)
            wrap_in = {{15{th_reg[18]}}, th_reg} + {{2{prod_reg[48]}}, prod_reg[48:17]}
                      + PI_Q + WRAP_BIAS;
        else
            wrap_in = {{15{th_reg[18]}}, th_reg} + {{2{prod_reg[47]}}, prod_reg[47:16]}
                      + PI_Q + WRAP_BIAS;
    end

    assign sub_val = TWO_PI_Q << cmd.cnt[3:0];

    always_comb
    begin
        ang     = $signed(rem_reg[19:0]) - PI_S;
        ang_f   = ang;
        ang_neg = 1'b0;
        if (ang > HALF_PI_S)
        begin
            ang_f   = ang - PI_S;
            ang_neg = 1'b1;
        end
        else if (ang < -HALF_PI_S)
        begin
            ang_f   = ang + PI_S;
            ang_neg = 1'b1;
        end
    end

    assign xs      = cx_reg >>> cmd.cnt;
    assign ys      = cy_reg >>> cmd.cnt;
    assign at      = atan_q30(cmd.cnt);
    assign theta_w = $signed(rem_reg[19:0]) - PI_S;
    assign sx_sum  = {px_reg[31], px_reg} + {xinc_reg[31], xinc_reg};
    assign sy_sum  = {py_reg[31], py_reg} + {yinc_reg[31], yinc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_gyro_reg  <= '0;
            prev_wheel_reg <= '0;
        end
        else if (cmd.load)
        begin
            prev_gyro_reg  <= gyro_z;
            prev_wheel_reg <= vel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= pose_x;
            py_reg <= pose_y;
            th_reg <= pose_theta;
            v_reg  <= pose_v;
            w_reg  <= pose_w;
            g_reg  <= gyro_z;
            t_reg  <= time_step;
            pv_reg <= sat32({{16{pv_sum[33]}}, pv_sum});
            pw_reg <= sat32({{16{pw_sum[33]}}, pw_sum});
        end
        if (cmd.mul_en)
            prod_reg <= ma * mb;
        if (cmd.mid_load || cmd.th_load)
            rem_reg <= wrap_in;
        else if (cmd.mod_step && (rem_reg >= sub_val))
            rem_reg <= rem_reg - sub_val;
        if (cmd.cord_init)
        begin
            cx_reg  <= CORDIC_GAIN;
            cy_reg  <= '0;
            cz_reg  <= {{14{ang_f[19]}}, ang_f} <<< 14;
            neg_reg <= ang_neg;
        end
        else if (cmd.cord_step)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed(at);
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed(at);
            end
        end
        if (cmd.xdir_ld)
            xdir_reg <= prod_reg[47:30];
        if (cmd.ydir_ld)
            ydir_reg <= prod_reg[47:30];
        if (cmd.xinc_ld)
            xinc_reg <= sat32(prod_reg[65:16]);
        if (cmd.yinc_ld)
            yinc_reg <= sat32(prod_reg[65:16]);
        if (cmd.jwy_ld)
            jwy_reg <= prod_reg[48:17];
        if (cmd.jwx_ld)
            jwx_reg <= prod_reg[48:17];
        if (cmd.out_load)
        begin
            pred_x      <= sat32({{17{sx_sum[32]}}, sx_sum});
            pred_y      <= sat32({{17{sy_sum[32]}}, sy_sum});
            pred_theta  <= theta_w[18:0];
            pred_v      <= pv_reg;
            pred_w      <= pw_reg;
            jac_theta_x <= sat32({{17{nyinc[32]}}, nyinc});
            jac_theta_y <= xinc_reg;
            jac_v_x     <= {{14{xdir_reg[17]}}, xdir_reg};
            jac_v_y     <= {{14{ydir_reg[17]}}, ydir_reg};
            jac_w_x     <= jwx_reg;
            jac_w_y     <= jwy_reg;
        end
    end

endmodule
`default_nettype wire

// ===== src/uekf_chk.sv =====
`default_nettype none
module uekf_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [18:0] pred_theta
);

    // A held result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");

    // After an item is taken, no further item is taken in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while the previous one is in work");

    // A result never appears in the cycle right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // The predicted heading is wrapped whenever a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pred_theta >= -19'sd205887 && pred_theta <= 19'sd205887))
        else $error("predicted heading outside the wrapped range");

endmodule

bind unicycle_ekf_predict uekf_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pred_theta (out_ch.pred_theta)
);
`default_nettype wire
